[hw/rtl/sst_pkg.sv]
package sst_pkg;

    // field widths
    localparam int DATA_W      = 32;
    localparam int REQ_W       = 2;
    localparam int COUNT_OUT_W = 5;

    // default table depth
    localparam int DEFAULT_CAPACITY = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    // shift command broadcast to every cell
    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } sst_ctl_t;

    // compare status a cell reports to the top and to its upper neighbor
    typedef struct packed {
        logic occ;
        logic eq;
        logic gt;
    } sst_stat_t;

endpackage

[hw/rtl/sst_cell.sv]
module sst_cell
(
    input  logic                             clk,
    input  logic signed [sst_pkg::DATA_W-1:0] value,
    input  sst_pkg::sst_ctl_t                ctl,
    input  logic                             occ,
    input  logic signed [sst_pkg::DATA_W-1:0] prev_entry,
    input  sst_pkg::sst_stat_t               prev_stat,
    input  logic signed [sst_pkg::DATA_W-1:0] next_entry,
    output logic signed [sst_pkg::DATA_W-1:0] entry,
    output sst_pkg::sst_stat_t               stat
);

    logic signed [sst_pkg::DATA_W-1:0] entry_reg;
    logic signed [sst_pkg::DATA_W-1:0] entry_next;

    // local compare against the request value
    always_comb
    begin
        stat.occ = occ;
        stat.eq  = occ && (entry_reg == value);
        stat.gt  = occ && (entry_reg > value);
    end

    // pick up from the lower neighbor, the request, or the upper neighbor
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.do_insert)
        begin
            if (prev_stat.gt)
            begin
                entry_next = prev_entry;
            end
            else if (stat.gt || !occ)
            begin
                entry_next = value;
            end
        end
        else if (ctl.do_remove)
        begin
            if (stat.gt || stat.eq)
            begin
                entry_next = next_entry;
            end
        end
    end

    // entry storage, meaningful only while occupied
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[hw/rtl/sorted_set_table.sv]
// sorted_set_table: a set of distinct signed 32-bit values kept in ascending
// order in a row of CAPACITY cells.
// request channel: a request (req_type, value) is taken at a rising edge with
// start high and busy low. busy stays low: a new request may follow every
// cycle. req_type selects insert, remove or membership query; code 3 acts as
// a query.
// result channel: in the cycle after a request is taken, done is high for one
// cycle with was_present, count_after and rejected. Throughput is 1 request
// per cycle, as each request is served by a single compare-and-shift pass in
// which every cell compares its entry with the value and takes its new entry
// from itself, its neighbor or the request.
// results are never held off; the receiver has to take them as they appear.
// reset: the set is empty and no result is pending; entry contents are not
// cleared, since only occupied cells are ever read.
// count_after carries the low 5 bits of the count.
module sorted_set_table
#(
    parameter int CAPACITY = sst_pkg::DEFAULT_CAPACITY
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [sst_pkg::REQ_W-1:0]              req_type,
    input  logic signed [sst_pkg::DATA_W-1:0]      value,
    output logic                                   done,
    output logic                                   was_present,
    output logic [sst_pkg::COUNT_OUT_W-1:0]        count_after,
    output logic                                   rejected
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    logic          was_present_reg;
    logic          was_present_next;
    logic          rejected_reg;
    logic          rejected_next;
    logic [sst_pkg::COUNT_OUT_W-1:0] count_after_reg;

    logic signed [sst_pkg::DATA_W-1:0] entries [CAPACITY];
    sst_pkg::sst_stat_t                stats   [CAPACITY];
    logic [CAPACITY-1:0]               eq_vec;
    logic                              accept;
    logic                              present;
    logic                              full;
    sst_pkg::sst_ctl_t                 ctl;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [sst_pkg::DATA_W-1:0] prev_entry;
        sst_pkg::sst_stat_t                prev_stat;
        logic signed [sst_pkg::DATA_W-1:0] next_entry;
        logic                              occ;

        assign occ = CW'(i) < count_reg;

        if (i == 0)
        begin : g_first
            assign prev_entry = '0;
            assign prev_stat  = '0;
        end
        else
        begin : g_mid
            assign prev_entry = entries[i-1];
            assign prev_stat  = stats[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_entry = '0;
        end
        else
        begin : g_up
            assign next_entry = entries[i+1];
        end

        sst_cell u_cell
        (
            .clk        (clk),
            .value      (value),
            .ctl        (ctl),
            .occ        (occ),
            .prev_entry (prev_entry),
            .prev_stat  (prev_stat),
            .next_entry (next_entry),
            .entry      (entries[i]),
            .stat       (stats[i])
        );

        assign eq_vec[i] = stats[i].eq;
    end

    // request decode and count update
    always_comb
    begin
        present = |eq_vec;
        full    = (count_reg == CW'(CAPACITY));

        ctl.do_insert = accept && (req_type == sst_pkg::REQ_INSERT) && !present && !full;
        ctl.do_remove = accept && (req_type == sst_pkg::REQ_REMOVE) && present;

        count_next = count_reg;
        if (ctl.do_insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.do_remove)
        begin
            count_next = count_reg - CW'(1);
        end

        was_present_next = present;
        rejected_next    = (req_type == sst_pkg::REQ_INSERT) && !present && full;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            was_present_reg <= was_present_next;
            rejected_reg    <= rejected_next;
            count_after_reg <= sst_pkg::COUNT_OUT_W'(count_next);
        end
    end

    assign done        = done_reg;
    assign was_present = was_present_reg;
    assign rejected    = rejected_reg;
    assign count_after = count_after_reg;

endmodule

[hw/rtl/sst_checker.sv]
module sst_checker
#(
    parameter int CAPACITY = sst_pkg::DEFAULT_CAPACITY
)
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [sst_pkg::REQ_W-1:0]         req_type,
    input logic                              done,
    input logic                              was_present,
    input logic [sst_pkg::COUNT_OUT_W-1:0]   count_after,
    input logic                              rejected
);

    // every request gets its result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done)
        else $error("request without result");

    // no result without a request
    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without request");

    // a refused insert only happens for a new value on a full table
    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && rejected |-> !was_present && count_after == sst_pkg::COUNT_OUT_W'(CAPACITY))
        else $error("refusal on a table that is not full");

    // only inserts are refused
    a_reject_insert: assert property (@(posedge clk) disable iff (!rst_n)
        done && rejected |-> $past(req_type) == sst_pkg::REQ_INSERT)
        else $error("refusal of a request that is not an insert");

endmodule

bind sorted_set_table sst_checker #(.CAPACITY(CAPACITY)) u_sst_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .done        (done),
    .was_present (was_present),
    .count_after (count_after),
    .rejected    (rejected)
);
